[rtl/core/dfgpp_pkg.sv]
// Package for the DLE framed gain packet parser.
// Holds the framing byte codes, the result kind codes and the result struct.
// No dependencies.
package dfgpp_pkg;

	localparam logic [7:0] BYTE_DLE     = 8'h10;
	localparam logic [7:0] BYTE_ETX     = 8'h03;
	localparam logic [7:0] THROTTLE_MAX = 8'd100;
	localparam logic [3:0] LAST_INDEX   = 4'd13;

	localparam logic [1:0] KIND_THROTTLE = 2'd0;
	localparam logic [1:0] KIND_PROP     = 2'd1;
	localparam logic [1:0] KIND_INTEG    = 2'd2;
	localparam logic [1:0] KIND_DERIV    = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [31:0] value;
	} result_t;

endpackage

[rtl/core/dfgpp_in_reg.sv]
// Input register of the DLE framed gain packet parser.
// Holds one received byte until the parse stage advances. Uses dfgpp_pkg.
module dfgpp_in_reg
	import dfgpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic       valid_q;
	logic [7:0] byte_q;

	assign s_tready = !valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_q <= s_tdata;
		end
	end

	assign valid_s1 = valid_q;
	assign byte_s1  = byte_q;

endmodule

[rtl/core/dfgpp_parse.sv]
// Framing state and field assembly of the DLE framed gain packet parser.
// Updates the packet state for one byte and forms the result. Uses dfgpp_pkg.
module dfgpp_parse
	import dfgpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	output result_t    res
);

	logic        in_packet_q;
	logic        escape_q;
	logic [3:0]  index_q;
	logic [31:0] acc_q;

	logic        in_packet_d;
	logic        escape_d;
	logic [3:0]  index_d;
	logic [31:0] acc_d;
	logic [3:0]  idx_m1;

	always_comb begin
		in_packet_d = in_packet_q;
		escape_d    = escape_q;
		index_d     = index_q;
		acc_d       = acc_q;
		res         = '0;
		idx_m1      = index_q - 4'd1;
		if (!in_packet_q) begin
			if (rx_byte == BYTE_DLE) begin
				in_packet_d = 1'b1;
				escape_d    = 1'b0;
				index_d     = 4'd0;
				acc_d       = '0;
			end
		end else if (rx_byte == BYTE_DLE && !escape_q) begin
			escape_d = 1'b1;
		end else if (rx_byte == BYTE_ETX) begin
			in_packet_d = 1'b0;
		end else begin
			escape_d = 1'b0;
			if (index_q == 4'd0) begin
				// throttle byte, saturate
				index_d   = 4'd1;
				res.valid = 1'b1;
				res.kind  = KIND_THROTTLE;
				res.value = {24'd0, (rx_byte > THROTTLE_MAX) ? THROTTLE_MAX : rx_byte};
			end else if (index_q < LAST_INDEX) begin
				if (idx_m1[1:0] == 2'd0) begin
					acc_d = {24'd0, rx_byte};
				end else begin
					acc_d = {acc_q[23:0], rx_byte};
				end
				index_d = index_q + 4'd1;
				if (index_q[1:0] == 2'd0) begin
					// last byte of a gain word: index 4, 8, 12 map to kinds 1..3
					res.valid = 1'b1;
					res.kind  = index_q[3:2];
					res.value = acc_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			escape_q    <= 1'b0;
			index_q     <= 4'd0;
			acc_q       <= '0;
		end else if (en) begin
			in_packet_q <= in_packet_d;
			escape_q    <= escape_d;
			index_q     <= index_d;
			acc_q       <= acc_d;
		end
	end

endmodule

[rtl/core/dfgpp_out_reg.sv]
// Result register of the DLE framed gain packet parser.
// Holds one finished result until the master side takes it. Uses dfgpp_pkg.
module dfgpp_out_reg
	import dfgpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	input  result_t     res,
	output logic        advance,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser
);

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [31:0] value_q;

	assign advance = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load_valid && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid && res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = kind_q;

endmodule

[rtl/core/dle_framed_gain_packet_parser_unit.sv]
// Top level of the DLE framed gain packet parser.
// Chains dfgpp_in_reg, dfgpp_parse and dfgpp_out_reg; uses dfgpp_pkg.
//
// Channel   Dir  Signals                     Beat content
// s_*       in   s_tvalid s_tready s_tdata   one received serial byte
// m_*       out  m_tvalid m_tready m_tdata   gain word or throttle value
//                          m_tuser           which value completed
//
// One byte per cycle is accepted while the result register is not stalled; a
// taken byte lands in the input register, and its result is then loaded into
// the result register. The single parse stage updates the framing state once
// per byte.
// arst_n clears the packet state to idle and empties both registers.
// A stalled result holds in the result register; the parse stage and the
// input register hold too, so s_tready drops only when both are full.
module dle_framed_gain_packet_parser_unit
	import dfgpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] field_value
	output logic [1:0]  m_tuser    // [1:0] field_kind
);

	logic       advance;   // result register can take the parse output
	logic       valid_s1;
	logic [7:0] byte_s1;
	result_t    res;

	// Hold the byte until the parse stage can advance.
	dfgpp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Advance the framing state only on a held byte that moves on.
	dfgpp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Drop bytes that complete nothing; register completed values.
	dfgpp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.res        (res),
		.advance    (advance),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
